// ----- hw/rtl/mccpsg_pkg.sv -----
`default_nettype none

package mccpsg_pkg;

  localparam int ADDR_W = 4;

  typedef logic [2:0] step_t;

  typedef enum logic [1:0] {
    TGT_RIGHT = 2'd0,
    TGT_LEFT  = 2'd1,
    TGT_BOTH  = 2'd2
  } target_t;

  // Controller numbers
  localparam logic [6:0] CC_TONE_A_MSB = 7'd20;
  localparam logic [6:0] CC_TONE_B_MSB = 7'd21;
  localparam logic [6:0] CC_TONE_C_MSB = 7'd22;
  localparam logic [6:0] CC_NOISE      = 7'd23;
  localparam logic [6:0] CC_MIX        = 7'd24;
  localparam logic [6:0] CC_LEVEL_A    = 7'd25;
  localparam logic [6:0] CC_LEVEL_B    = 7'd26;
  localparam logic [6:0] CC_LEVEL_C    = 7'd27;
  localparam logic [6:0] CC_ENV_HI     = 7'd28;
  localparam logic [6:0] CC_ENV_MID    = 7'd29;
  localparam logic [6:0] CC_ENV_LO     = 7'd30;
  localparam logic [6:0] CC_SHAPE      = 7'd31;
  localparam logic [6:0] CC_TONE_A_LSB = 7'd52;
  localparam logic [6:0] CC_TONE_B_LSB = 7'd53;
  localparam logic [6:0] CC_TONE_C_LSB = 7'd54;
  localparam logic [6:0] CC_HOLD       = 7'd80;

  // Chip register addresses
  localparam logic [3:0] REG_TONE_A  = 4'd0;
  localparam logic [3:0] REG_TONE_B  = 4'd2;
  localparam logic [3:0] REG_TONE_C  = 4'd4;
  localparam logic [3:0] REG_NOISE   = 4'd6;
  localparam logic [3:0] REG_MIXER   = 4'd7;
  localparam logic [3:0] REG_LEVEL_A = 4'd8;
  localparam logic [3:0] REG_LEVEL_B = 4'd9;
  localparam logic [3:0] REG_LEVEL_C = 4'd10;
  localparam logic [3:0] REG_ENV_LO  = 4'd11;
  localparam logic [3:0] REG_SHAPE   = 4'd13;

  localparam logic [3:0] BASE_CH_RESET = 4'd7;
  localparam logic [6:0] LATCH_LIMIT   = 7'd64;

  // Program entry points
  localparam step_t ENTRY_PAIR   = 3'd0;
  localparam step_t ENTRY_SINGLE = 3'd4;
  localparam step_t ENTRY_LATCH  = 3'd5;
  localparam step_t STEP_FLUSH   = 3'd6;

  typedef enum logic [3:0] {
    K_TONE_MSB,
    K_TONE_LSB,
    K_ENV_HI,
    K_ENV_MID,
    K_ENV_LO,
    K_SHR1,
    K_SHR2,
    K_SHR3,
    K_LATCH
  } kind_t;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_RD_LO,
    UOP_RD_HI,
    UOP_STORE,
    UOP_LATCH,
    UOP_FLUSH
  } uop_t;

  typedef enum logic {
    A_BASE,
    A_NEXT
  } asel_t;

  typedef enum logic [1:0] {
    D_BUF_LO,
    D_BUF_HI,
    D_SCALED
  } dsel_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_DONE,
    C_DONE_IF_SET,
    C_LOOP
  } cond_t;

  typedef struct packed {
    uop_t  op;
    asel_t asel;
    dsel_t dsel;
    logic  last;
    cond_t cond;
  } ucode_t;

  typedef struct packed {
    logic emit_wait;
    logic latch_set;
    logic flush_last;
  } seq_status_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t u;
    u = '{op: UOP_NOP, asel: A_BASE, dsel: D_SCALED, last: 1'b0, cond: C_DONE};
    unique case (s)
      3'd0: u = '{op: UOP_RD_LO, asel: A_BASE, dsel: D_BUF_LO, last: 1'b0, cond: C_NEXT};
      3'd1: u = '{op: UOP_RD_HI, asel: A_NEXT, dsel: D_BUF_LO, last: 1'b0, cond: C_NEXT};
      3'd2: u = '{op: UOP_STORE, asel: A_BASE, dsel: D_BUF_LO, last: 1'b0, cond: C_NEXT};
      3'd3: u = '{op: UOP_STORE, asel: A_NEXT, dsel: D_BUF_HI, last: 1'b1, cond: C_DONE};
      3'd4: u = '{op: UOP_STORE, asel: A_BASE, dsel: D_SCALED, last: 1'b1, cond: C_DONE};
      3'd5: u = '{op: UOP_LATCH, asel: A_BASE, dsel: D_SCALED, last: 1'b0,
                  cond: C_DONE_IF_SET};
      3'd6: u = '{op: UOP_FLUSH, asel: A_BASE, dsel: D_SCALED, last: 1'b0, cond: C_LOOP};
      default: u = '{op: UOP_NOP, asel: A_BASE, dsel: D_SCALED, last: 1'b0, cond: C_DONE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mccpsg_seq.sv -----
`default_nettype none

module mccpsg_seq (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire mccpsg_pkg::step_t        entry,
  input  wire mccpsg_pkg::seq_status_t  status,
  output logic                          busy,
  output mccpsg_pkg::ucode_t            cw
);
  import mccpsg_pkg::*;

  step_t step, step_next;
  logic  busy_next;

  assign cw = ucode_rom(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ENTRY_PAIR;
    end else begin
      busy <= busy_next;
      step <= step_next;
    end
  end

  always_comb begin
    step_next = step;
    busy_next = busy;
    if (start) begin
      busy_next = 1'b1;
      step_next = entry;
    end else if (busy && !status.emit_wait) begin
      unique case (cw.cond)
        C_NEXT: step_next = step + 3'd1;
        C_DONE: busy_next = 1'b0;
        C_DONE_IF_SET: begin
          if (status.latch_set) begin
            busy_next = 1'b0;
          end else begin
            step_next = step + 3'd1;
          end
        end
        C_LOOP: begin
          // stay on this step until the last flush write goes out
          if (status.flush_last) begin
            busy_next = 1'b0;
          end
        end
        default: busy_next = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/midi_cc_to_psg_register_mapper.sv -----
`default_nettype none
// MIDI control-change to sound-generator register mapper.
// Input channel: midi_channel, cc_number, cc_value with in_valid/in_stall; one
// event is taken when in_valid is high and in_stall low. in_stall is high while
// an event is being worked on, so events are handled one at a time.
// Output channel: target_chip, reg_addr, reg_data, last_write with
// out_valid/out_stall; one chip register write per item, last_write marks the
// final write of an event. A single output register holds the next write; while
// the receiver stalls, the sequencer waits on its emit step.
// Each event is taken, then runs its microprogram steps:
// level/noise/mixer/shape 1 step, tone and envelope periods 4 steps (two
// mirror reads, two writes), latch 1 step plus, when the hold is released,
// one step per flush write (NUM_REGS, or 2*NUM_REGS for the both-chips channel).
// A step that writes waits while the receiver stalls. Events on other channels or
// with unknown controllers are taken with no writes.
// The first write is registered and appears in the cycle after its step runs.
// Reset clears the latch, all shadow and mirror registers, the output register,
// and sets the base channel to 7. cfg_wr_en writes the base channel; write it
// only while idle.
module midi_cc_to_psg_register_mapper #(
  parameter int NUM_REGS = 14
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] midi_channel,
  input  wire logic [6:0] cc_number,
  input  wire logic [7:0] cc_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      target_chip,
  output logic [3:0]      reg_addr,
  output logic [7:0]      reg_data,
  output logic            last_write
);
  import mccpsg_pkg::*;

  localparam int IW = $clog2(NUM_REGS);

  // configuration and control state
  logic [3:0] base_ch;
  logic       latch_hold;
  logic [7:0] left_shadow  [NUM_REGS];
  logic [7:0] right_shadow [NUM_REGS];
  logic [7:0] left_mirror  [NUM_REGS];
  logic [7:0] right_mirror [NUM_REGS];

  // per-event datapath registers
  target_t    tgt;
  logic [6:0] val;
  kind_t      kind;
  logic [3:0] rb;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [IW-1:0] cnt;
  logic       side_right;

  // decode
  logic       hit;
  logic       act;
  target_t    tgt_d;
  kind_t      kind_d;
  logic [3:0] rb_d;
  step_t      entry_d;
  logic [4:0] ch_both, ch_left, ch_right;

  // sequencer
  logic        busy;
  ucode_t      cw;
  seq_status_t status;
  logic        accept;
  logic        start;

  // datapath
  logic [15:0]   old_val;
  logic [15:0]   buf_val;
  logic [7:0]    scaled;
  logic [3:0]    st_addr;
  logic [IW-1:0] st_idx;
  logic [7:0]    mirror_rd;
  logic [7:0]    store_data;
  logic          emit_req;
  logic          can_emit;
  logic          go;
  logic          flush_last;
  target_t       e_tgt;
  logic [3:0]    e_addr;
  logic [7:0]    e_data;
  logic          e_last;

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && act;

  assign ch_both  = {1'b0, base_ch};
  assign ch_left  = ch_both + 5'd1;
  assign ch_right = ch_both + 5'd2;

  always_comb begin
    hit   = 1'b1;
    tgt_d = TGT_BOTH;
    priority if (midi_channel == ch_both) begin
      tgt_d = TGT_BOTH;
    end else if (midi_channel == ch_left) begin
      tgt_d = TGT_LEFT;
    end else if (midi_channel == ch_right) begin
      tgt_d = TGT_RIGHT;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    act     = hit;
    kind_d  = K_SHR2;
    rb_d    = REG_TONE_A;
    entry_d = ENTRY_SINGLE;
    unique case (cc_number)
      CC_TONE_A_MSB: begin kind_d = K_TONE_MSB; rb_d = REG_TONE_A; entry_d = ENTRY_PAIR; end
      CC_TONE_B_MSB: begin kind_d = K_TONE_MSB; rb_d = REG_TONE_B; entry_d = ENTRY_PAIR; end
      CC_TONE_C_MSB: begin kind_d = K_TONE_MSB; rb_d = REG_TONE_C; entry_d = ENTRY_PAIR; end
      CC_TONE_A_LSB: begin kind_d = K_TONE_LSB; rb_d = REG_TONE_A; entry_d = ENTRY_PAIR; end
      CC_TONE_B_LSB: begin kind_d = K_TONE_LSB; rb_d = REG_TONE_B; entry_d = ENTRY_PAIR; end
      CC_TONE_C_LSB: begin kind_d = K_TONE_LSB; rb_d = REG_TONE_C; entry_d = ENTRY_PAIR; end
      CC_ENV_HI:     begin kind_d = K_ENV_HI;   rb_d = REG_ENV_LO; entry_d = ENTRY_PAIR; end
      CC_ENV_MID:    begin kind_d = K_ENV_MID;  rb_d = REG_ENV_LO; entry_d = ENTRY_PAIR; end
      CC_ENV_LO:     begin kind_d = K_ENV_LO;   rb_d = REG_ENV_LO; entry_d = ENTRY_PAIR; end
      CC_NOISE:      begin kind_d = K_SHR2; rb_d = REG_NOISE;   end
      CC_MIX:        begin kind_d = K_SHR1; rb_d = REG_MIXER;   end
      CC_LEVEL_A:    begin kind_d = K_SHR2; rb_d = REG_LEVEL_A; end
      CC_LEVEL_B:    begin kind_d = K_SHR2; rb_d = REG_LEVEL_B; end
      CC_LEVEL_C:    begin kind_d = K_SHR2; rb_d = REG_LEVEL_C; end
      CC_SHAPE:      begin kind_d = K_SHR3; rb_d = REG_SHAPE;   end
      CC_HOLD:       begin kind_d = K_LATCH; entry_d = ENTRY_LATCH; end
      default:       act = 1'b0;
    endcase
  end

  mccpsg_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .entry  (entry_d),
    .status (status),
    .busy   (busy),
    .cw     (cw)
  );

  // merge the new field, taken from the 7-bit value, into the period read back from the mirror
  assign old_val = {hi, lo};

  always_comb begin
    buf_val = 16'd0;
    scaled  = 8'd0;
    unique case (kind)
      K_TONE_MSB: buf_val = {4'd0, val, old_val[4:0]};
      K_TONE_LSB: buf_val = {4'd0, old_val[11:5], val[6:2]};
      K_ENV_HI:   buf_val = {val, old_val[8:0]};
      K_ENV_MID:  buf_val = {old_val[15:9], val, old_val[1:0]};
      K_ENV_LO:   buf_val = {old_val[15:2], val[6:5]};
      K_SHR1:     scaled  = {2'd0, val[6:1]};
      K_SHR2:     scaled  = {3'd0, val[6:2]};
      K_SHR3:     scaled  = {4'd0, val[6:3]};
      default:    scaled  = 8'd0;
    endcase
  end

  assign st_addr = (cw.asel == A_NEXT) ? rb + 4'd1 : rb;
  assign st_idx  = IW'(st_addr);

  // the both-chips channel reads back from the right mirror
  assign mirror_rd = (tgt == TGT_LEFT) ? left_mirror[st_idx] : right_mirror[st_idx];

  always_comb begin
    unique case (cw.dsel)
      D_BUF_LO: store_data = buf_val[7:0];
      D_BUF_HI: store_data = buf_val[15:8];
      D_SCALED: store_data = scaled;
      default:  store_data = scaled;
    endcase
  end

  assign flush_last = (cnt == IW'(NUM_REGS - 1)) && !(tgt == TGT_BOTH && !side_right);

  always_comb begin
    if (cw.op == UOP_FLUSH) begin
      e_tgt  = side_right ? TGT_RIGHT : TGT_LEFT;
      e_addr = ADDR_W'(cnt);
      e_data = side_right ? right_shadow[cnt] : left_shadow[cnt];
      e_last = flush_last;
    end else begin
      e_tgt  = tgt;
      e_addr = st_addr;
      e_data = store_data;
      e_last = cw.last;
    end
  end

  assign emit_req = busy && ((cw.op == UOP_STORE && !latch_hold) || cw.op == UOP_FLUSH);
  assign can_emit = !out_valid || !out_stall;
  assign go       = busy && !(emit_req && !can_emit);

  assign status.emit_wait  = emit_req && !can_emit;
  assign status.latch_set  = val > LATCH_LIMIT;
  assign status.flush_last = flush_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_ch    <= BASE_CH_RESET;
      latch_hold <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        left_shadow[i]  <= 8'd0;
        right_shadow[i] <= 8'd0;
        left_mirror[i]  <= 8'd0;
        right_mirror[i] <= 8'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        base_ch <= cfg_wr_data;
      end
      if (go && emit_req) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (go && emit_req) begin
        if (e_tgt == TGT_LEFT || e_tgt == TGT_BOTH) begin
          left_mirror[IW'(e_addr)] <= e_data;
        end
        if (e_tgt == TGT_RIGHT || e_tgt == TGT_BOTH) begin
          right_mirror[IW'(e_addr)] <= e_data;
        end
      end
      if (go && cw.op == UOP_STORE) begin
        if (tgt == TGT_LEFT || tgt == TGT_BOTH) begin
          left_shadow[st_idx] <= store_data;
        end
        if (tgt == TGT_RIGHT || tgt == TGT_BOTH) begin
          right_shadow[st_idx] <= store_data;
        end
      end
      if (go && cw.op == UOP_LATCH) begin
        latch_hold <= status.latch_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tgt        <= tgt_d;
      val        <= cc_value[6:0];
      kind       <= kind_d;
      rb         <= rb_d;
      cnt        <= '0;
      side_right <= (tgt_d == TGT_RIGHT);
    end
    if (go && cw.op == UOP_RD_LO) begin
      lo <= mirror_rd;
    end
    if (go && cw.op == UOP_RD_HI) begin
      hi <= mirror_rd;
    end
    // both-chips flush: left then right for each register
    if (go && cw.op == UOP_FLUSH) begin
      if (tgt == TGT_BOTH && !side_right) begin
        side_right <= 1'b1;
      end else begin
        cnt        <= cnt + IW'(1);
        side_right <= (tgt == TGT_RIGHT);
      end
    end
    if (go && emit_req) begin
      target_chip <= e_tgt;
      reg_addr    <= e_addr;
      reg_data    <= e_data;
      last_write  <= e_last;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mccpsg_checker.sv -----
`default_nettype none

module mccpsg_checker #(
  parameter int NUM_REGS = 14
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] target_chip,
  input wire logic [3:0] reg_addr
);

  // a write waiting on a stalled receiver is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output write dropped while stalled");

  // reset empties the output register
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_target: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> target_chip != 2'd3)
    else $error("invalid target chip");

  a_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(reg_addr) < NUM_REGS)
    else $error("register address beyond the bank");

endmodule

bind midi_cc_to_psg_register_mapper mccpsg_checker #(.NUM_REGS(NUM_REGS)) u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .target_chip (target_chip),
  .reg_addr    (reg_addr)
);

`default_nettype wire
